// ===== rtl/rnt_pkg.sv =====
// ----------------------------------------------------------------------------
// rnt_pkg
// Types and constants shared by the read-name tokenizer modules.
// ----------------------------------------------------------------------------
package rnt_pkg;

   localparam int KIND_W  = 3;
   localparam int VALUE_W = 30;
   localparam int CHAR_W  = 8;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0]  CHAR_UC_A = 8'h41;
   localparam logic [CHAR_W-1:0]  CHAR_UC_Z = 8'h5a;
   localparam logic [CHAR_W-1:0]  CHAR_LC_A = 8'h61;
   localparam logic [CHAR_W-1:0]  CHAR_LC_Z = 8'h7a;
   localparam logic [3:0]         DEC_BASE  = 4'd10;
   localparam logic [VALUE_W-1:0] DELTA_MAX = 30'd255;

   typedef enum logic [KIND_W-1:0] {
      KIND_DIFF   = 3'd0,
      KIND_STRING = 3'd1,
      KIND_CHAR   = 3'd2,
      KIND_DIGITS = 3'd3,
      KIND_DELTA  = 3'd4,
      KIND_MATCH  = 3'd5,
      KIND_END    = 3'd6
   } token_kind_type;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_ALPHA,
      PEND_ZERO,
      PEND_NUM
   } pend_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OPEN,
      ST_CHAR,
      ST_START,
      ST_LAST,
      ST_END,
      ST_CLOSE,
      ST_FIN,
      ST_TREAD,
      ST_TLOOK,
      ST_SCMP,
      ST_SDEC,
      ST_SEMIT
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_OPEN,
      OP_APPEND,
      OP_FLUSH_LOAD,
      OP_START,
      OP_CHAR_LOAD,
      OP_END_LOAD,
      OP_CLOSE,
      OP_FIN,
      OP_TREAD,
      OP_TLOOK,
      OP_SCMP,
      OP_SDEC,
      OP_SEMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic in_name;
      logic present;
      logic last;
      logic append_ok;
      logic pend_busy;
      logic start_is_char;
      logic tok_is_string;
      logic idx_last;
      logic eq;
      logic push_ok;
      logic fin_done;
   } dp_status_type;

endpackage

// ===== rtl/rnt_if.sv =====
// ----------------------------------------------------------------------------
// rnt_req_if / rnt_rsp_if
// Valid/ready channels for name characters and token results.
// ----------------------------------------------------------------------------
interface rnt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       char_present;
   logic       name_last;

   modport source (output valid, output char_code, output char_present,
                   output name_last, input ready);
   modport sink   (input valid, input char_code, input char_present,
                   input name_last, output ready);
endinterface

interface rnt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [29:0] token_value;
   logic [7:0]  string_char;
   logic        token_done;
   logic        run_last;

   modport source (output valid, output token_kind, output token_value,
                   output string_char, output token_done, output run_last,
                   input ready);
   modport sink   (input valid, input token_kind, input token_value,
                   input string_char, input token_done, input run_last,
                   output ready);
endinterface

// ===== rtl/rnt_ctl.sv =====
// ----------------------------------------------------------------------------
// rnt_ctl
// Sequencer: walks one item through open, character, flush and end steps,
// and each token through table lookup, string compare and emission.
// ----------------------------------------------------------------------------
module rnt_ctl
   import rnt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   ctl_state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_OPEN;
         end
         ST_OPEN: begin
            if (!status.in_name) begin
               ret_in   = ST_CHAR;
               state_in = ST_TREAD;
            end else begin
               state_in = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (!status.present || status.append_ok) begin
               state_in = ST_LAST;
            end else if (status.pend_busy) begin
               ret_in   = ST_START;
               state_in = ST_TREAD;
            end else begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.start_is_char) begin
               ret_in   = ST_LAST;
               state_in = ST_TREAD;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (!status.last) begin
               state_in = ST_FIN;
            end else if (status.pend_busy) begin
               ret_in   = ST_END;
               state_in = ST_TREAD;
            end else begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            ret_in   = ST_CLOSE;
            state_in = ST_TREAD;
         end
         ST_CLOSE: state_in = ST_FIN;
         ST_FIN: begin
            if (status.fin_done) state_in = ST_IDLE;
         end
         ST_TREAD: state_in = ST_TLOOK;
         ST_TLOOK: begin
            if (status.tok_is_string) state_in = ST_SCMP;
            else if (status.push_ok)  state_in = ret_ff;
         end
         ST_SCMP: begin
            if (status.idx_last) state_in = ST_SDEC;
         end
         ST_SDEC: begin
            if (!status.eq)          state_in = ST_SEMIT;
            else if (status.push_ok) state_in = ret_ff;
         end
         ST_SEMIT: begin
            if (status.push_ok && status.idx_last) state_in = ret_ff;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LATCH;
         end
         ST_OPEN: begin
            if (!status.in_name) cmd.op = OP_OPEN;
         end
         ST_CHAR: begin
            if (status.present) begin
               if (status.append_ok)      cmd.op = OP_APPEND;
               else if (status.pend_busy) cmd.op = OP_FLUSH_LOAD;
            end
         end
         ST_START: begin
            if (status.start_is_char) cmd.op = OP_CHAR_LOAD;
            else                      cmd.op = OP_START;
         end
         ST_LAST: begin
            if (status.last && status.pend_busy) cmd.op = OP_FLUSH_LOAD;
         end
         ST_END:   cmd.op = OP_END_LOAD;
         ST_CLOSE: cmd.op = OP_CLOSE;
         ST_FIN:   cmd.op = OP_FIN;
         ST_TREAD: cmd.op = OP_TREAD;
         ST_TLOOK: cmd.op = OP_TLOOK;
         ST_SCMP:  cmd.op = OP_SCMP;
         ST_SDEC:  cmd.op = OP_SDEC;
         ST_SEMIT: cmd.op = OP_SEMIT;
         default:  cmd.op = OP_NONE;
      endcase
   end

endmodule

// ===== rtl/rnt_dp.sv =====
// ----------------------------------------------------------------------------
// rnt_dp
// Datapath: pending token, previous-name tables, compare and result staging.
// ----------------------------------------------------------------------------
module rnt_dp
   import rnt_pkg::*;
#(
   parameter int MAX_TOKENS      = 64,
   parameter int MAX_STRING_LEN  = 32,
   parameter int NUMBER_CAP_LOG2 = 26
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic                req_char_present,
   input  logic                req_name_last,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [KIND_W-1:0]   rsp_token_kind,
   output logic [VALUE_W-1:0]  rsp_token_value,
   output logic [CHAR_W-1:0]   rsp_string_char,
   output logic                rsp_token_done,
   output logic                rsp_run_last,
   input  dp_cmd_type          cmd,
   output dp_status_type       status
);

   localparam int PW  = $clog2(MAX_TOKENS + 1);
   localparam int TIW = $clog2(MAX_TOKENS);
   localparam int LW  = $clog2(MAX_STRING_LEN + 1);
   localparam int IW  = $clog2(MAX_STRING_LEN);
   localparam int SAW = $clog2(MAX_TOKENS * MAX_STRING_LEN);
   localparam int NVW = NUMBER_CAP_LOG2 + 4;
   localparam int SDEPTH = MAX_TOKENS * MAX_STRING_LEN;

   // item
   logic [CHAR_W-1:0] chr_ff;
   logic              present_ff, last_ff;
   // name state
   logic              in_name_ff, in_name_in;
   logic [PW-1:0]     position_ff, position_in;
   logic [PW-1:0]     prev_count_ff, prev_count_in;
   // pending token
   pend_kind_type     pend_kind_ff, pend_kind_in;
   logic [NVW-1:0]    pend_value_ff, pend_value_in;
   logic [LW-1:0]     pend_len_ff, pend_len_in;
   // token in flight
   token_kind_type    tok_kind_ff, tok_kind_in;
   logic [VALUE_W-1:0] tok_value_ff, tok_value_in;
   logic [LW-1:0]     tok_len_ff, tok_len_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              eq_ff, eq_in;
   // staging
   logic              hold_valid_ff, hold_valid_in;
   logic [KIND_W-1:0] hold_kind_ff, hold_kind_in;
   logic [VALUE_W-1:0] hold_value_ff, hold_value_in;
   logic [CHAR_W-1:0] hold_char_ff, hold_char_in;
   logic              hold_done_ff, hold_done_in;
   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_done_ff, out_done_in;
   logic              out_last_ff, out_last_in;

   // memories
   logic [KIND_W-1:0]  prev_kind_mem  [MAX_TOKENS];
   logic [VALUE_W-1:0] prev_value_mem [MAX_TOKENS];
   logic [LW-1:0]      prev_len_mem   [MAX_TOKENS];
   logic [CHAR_W-1:0]  prev_str_mem   [SDEPTH];
   logic [CHAR_W-1:0]  pend_mem       [MAX_STRING_LEN];
   logic [KIND_W-1:0]  pk_rd_ff;
   logic [VALUE_W-1:0] pv_rd_ff;
   logic [LW-1:0]      pl_rd_ff;
   logic [CHAR_W-1:0]  ps_rd_ff, pb_rd_ff;

   logic               meta_we, str_we, pend_we;
   logic [LW-1:0]      pend_waddr;
   logic [CHAR_W-1:0]  pend_wdata;
   logic [TIW-1:0]     tidx;
   logic [SAW-1:0]     sbase, s_raddr, s_waddr;

   // decode and compare helpers
   logic               is_alpha, is_digit, is_zero;
   logic               have, p_ok, idx_last, out_free, push_ok;
   logic [NVW-1:0]     cap, digit_val;
   logic [VALUE_W-1:0] diff;
   logic               push;
   logic [KIND_W-1:0]  push_kind;
   logic [VALUE_W-1:0] push_value;
   logic [CHAR_W-1:0]  push_char;
   logic               push_done;
   logic               commit;

   always_comb begin
      is_alpha = (chr_ff >= CHAR_UC_A && chr_ff <= CHAR_UC_Z) ||
                 (chr_ff >= CHAR_LC_A && chr_ff <= CHAR_LC_Z);
      is_digit = chr_ff >= CHAR_ZERO && chr_ff <= CHAR_NINE;
      is_zero  = chr_ff == CHAR_ZERO;
      cap      = NVW'(1) << NUMBER_CAP_LOG2;
      digit_val = NVW'(chr_ff - CHAR_ZERO);
      p_ok     = position_ff < PW'(MAX_TOKENS);
      have     = (position_ff < prev_count_ff) && p_ok;
      idx_last = (LW'(idx_ff) + LW'(1)) == tok_len_ff;
      out_free = !out_valid_ff || rsp_ready;
      push_ok  = !hold_valid_ff || out_free;
      diff     = tok_value_ff - pv_rd_ff;
      tidx     = position_ff[TIW-1:0];
      sbase    = SAW'(tidx) * SAW'(MAX_STRING_LEN);
      s_waddr  = sbase + SAW'(idx_ff);
      s_raddr  = sbase + SAW'(idx_in);
   end

   always_comb begin
      status.in_name       = in_name_ff;
      status.present       = present_ff;
      status.last          = last_ff;
      status.pend_busy     = pend_kind_ff != PEND_NONE;
      status.start_is_char = !is_alpha && !is_digit;
      status.tok_is_string = tok_kind_ff == KIND_STRING;
      status.idx_last      = idx_last;
      status.eq            = eq_ff;
      status.push_ok       = push_ok;
      status.fin_done      = !hold_valid_ff || out_free;
      if (is_alpha)
         status.append_ok = pend_kind_ff == PEND_ALPHA && pend_len_ff < LW'(MAX_STRING_LEN);
      else if (is_digit && pend_kind_ff == PEND_NUM && pend_value_ff < cap)
         status.append_ok = 1'b1;
      else if (is_zero)
         status.append_ok = pend_kind_ff == PEND_ZERO && pend_len_ff < LW'(MAX_STRING_LEN);
      else
         status.append_ok = 1'b0;
   end

   always_comb begin
      in_name_in    = in_name_ff;
      position_in   = position_ff;
      prev_count_in = prev_count_ff;
      pend_kind_in  = pend_kind_ff;
      pend_value_in = pend_value_ff;
      pend_len_in   = pend_len_ff;
      tok_kind_in   = tok_kind_ff;
      tok_value_in  = tok_value_ff;
      tok_len_in    = tok_len_ff;
      idx_in        = idx_ff;
      eq_in         = eq_ff;
      pend_we       = 1'b0;
      pend_waddr    = pend_len_ff;
      pend_wdata    = chr_ff;
      str_we        = 1'b0;
      push          = 1'b0;
      push_kind     = tok_kind_ff;
      push_value    = '0;
      push_char     = '0;
      push_done     = 1'b1;
      commit        = 1'b0;

      case (cmd.op)
         OP_OPEN: begin
            pend_kind_in  = PEND_NONE;
            pend_value_in = '0;
            pend_len_in   = '0;
            position_in   = '0;
            in_name_in    = 1'b1;
            tok_kind_in   = KIND_DIFF;
            tok_value_in  = VALUE_W'(prev_count_ff != '0);
            tok_len_in    = '0;
         end
         OP_APPEND: begin
            if (is_alpha || !(is_digit && pend_kind_ff == PEND_NUM)) begin
               pend_we     = 1'b1;
               pend_len_in = pend_len_ff + LW'(1);
            end else begin
               pend_value_in = pend_value_ff * NVW'(DEC_BASE) + digit_val;
            end
         end
         OP_FLUSH_LOAD: begin
            tok_kind_in   = (pend_kind_ff == PEND_NUM) ? KIND_DIGITS : KIND_STRING;
            tok_value_in  = (pend_kind_ff == PEND_NUM) ? VALUE_W'(pend_value_ff) : '0;
            tok_len_in    = pend_len_ff;
            pend_kind_in  = PEND_NONE;
            pend_value_in = '0;
            pend_len_in   = '0;
         end
         OP_START: begin
            pend_waddr = '0;
            if (is_alpha || is_zero) begin
               pend_kind_in = is_alpha ? PEND_ALPHA : PEND_ZERO;
               pend_we      = 1'b1;
               pend_len_in  = LW'(1);
            end else begin
               pend_kind_in  = PEND_NUM;
               pend_value_in = digit_val;
            end
         end
         OP_CHAR_LOAD: begin
            tok_kind_in  = KIND_CHAR;
            tok_value_in = VALUE_W'(chr_ff);
            tok_len_in   = '0;
         end
         OP_END_LOAD: begin
            tok_kind_in  = KIND_END;
            tok_value_in = '0;
            tok_len_in   = '0;
         end
         OP_CLOSE: begin
            prev_count_in = position_ff;
            position_in   = '0;
            in_name_in    = 1'b0;
         end
         OP_TREAD: idx_in = '0;
         OP_TLOOK: begin
            if (tok_kind_ff == KIND_STRING) begin
               eq_in = have && pk_rd_ff == KIND_STRING && pl_rd_ff == tok_len_ff;
            end else begin
               push       = push_ok;
               commit     = push_ok;
               push_value = tok_value_ff;
               if (tok_kind_ff == KIND_DIGITS && have && pk_rd_ff == KIND_DIGITS) begin
                  if (pv_rd_ff == tok_value_ff) begin
                     push_kind  = KIND_MATCH;
                     push_value = '0;
                  end else if (tok_value_ff > pv_rd_ff && diff <= DELTA_MAX) begin
                     push_kind  = KIND_DELTA;
                     push_value = diff;
                  end
               end else if (tok_kind_ff == KIND_CHAR && have && pk_rd_ff == KIND_CHAR &&
                            pv_rd_ff == tok_value_ff) begin
                  push_kind  = KIND_MATCH;
                  push_value = '0;
               end
            end
         end
         OP_SCMP: begin
            // compare one byte and overwrite it with the new one
            eq_in  = eq_ff && (ps_rd_ff == pb_rd_ff);
            str_we = p_ok;
            if (!idx_last) idx_in = idx_ff + IW'(1);
         end
         OP_SDEC: begin
            idx_in = '0;
            if (eq_ff) begin
               push      = push_ok;
               commit    = push_ok;
               push_kind = KIND_MATCH;
            end
         end
         OP_SEMIT: begin
            push      = push_ok;
            push_kind = KIND_STRING;
            push_char = pb_rd_ff;
            push_done = idx_last;
            commit    = push_ok && idx_last;
            if (push_ok && !idx_last) idx_in = idx_ff + IW'(1);
         end
         default: ;
      endcase

      if (commit && p_ok) position_in = position_ff + PW'(1);
   end

   assign meta_we = commit && p_ok;

   // result staging: hold keeps the newest result until it is known
   // whether it closes the item
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_value_in = hold_value_ff;
      hold_char_in  = hold_char_ff;
      hold_done_in  = hold_done_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_value_in  = out_value_ff;
      out_char_in   = out_char_ff;
      out_done_in   = out_done_ff;
      out_last_in   = out_last_ff;
      if ((push || (cmd.op == OP_FIN && out_free)) && hold_valid_ff) begin
         out_valid_in = 1'b1;
         out_kind_in  = hold_kind_ff;
         out_value_in = hold_value_ff;
         out_char_in  = hold_char_ff;
         out_done_in  = hold_done_ff;
         out_last_in  = cmd.op == OP_FIN;
         hold_valid_in = 1'b0;
      end
      if (push) begin
         hold_valid_in = 1'b1;
         hold_kind_in  = push_kind;
         hold_value_in = push_value;
         hold_char_in  = push_char;
         hold_done_in  = push_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_name_ff    <= 1'b0;
         position_ff   <= '0;
         prev_count_ff <= '0;
         pend_kind_ff  <= PEND_NONE;
         pend_value_ff <= '0;
         pend_len_ff   <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_name_ff    <= in_name_in;
         position_ff   <= position_in;
         prev_count_ff <= prev_count_in;
         pend_kind_ff  <= pend_kind_in;
         pend_value_ff <= pend_value_in;
         pend_len_ff   <= pend_len_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LATCH) begin
         chr_ff     <= req_char_code;
         present_ff <= req_char_present;
         last_ff    <= req_name_last;
      end
      tok_kind_ff   <= tok_kind_in;
      tok_value_ff  <= tok_value_in;
      tok_len_ff    <= tok_len_in;
      idx_ff        <= idx_in;
      eq_ff         <= eq_in;
      hold_kind_ff  <= hold_kind_in;
      hold_value_ff <= hold_value_in;
      hold_char_ff  <= hold_char_in;
      hold_done_ff  <= hold_done_in;
      out_kind_ff   <= out_kind_in;
      out_value_ff  <= out_value_in;
      out_char_ff   <= out_char_in;
      out_done_ff   <= out_done_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         prev_kind_mem[tidx]  <= tok_kind_ff;
         prev_value_mem[tidx] <= tok_value_ff;
         prev_len_mem[tidx]   <= (tok_kind_ff == KIND_STRING) ? tok_len_ff : '0;
      end
      pk_rd_ff <= prev_kind_mem[tidx];
      pv_rd_ff <= prev_value_mem[tidx];
      pl_rd_ff <= prev_len_mem[tidx];
   end

   always_ff @(posedge clock) begin
      if (str_we) prev_str_mem[s_waddr] <= pb_rd_ff;
      ps_rd_ff <= prev_str_mem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[pend_waddr[IW-1:0]] <= pend_wdata;
      pb_rd_ff <= pend_mem[idx_in];
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_token_kind  = out_kind_ff;
   assign rsp_token_value = out_value_ff;
   assign rsp_string_char = out_char_ff;
   assign rsp_token_done  = out_done_ff;
   assign rsp_run_last    = out_last_ff;

endmodule

// ===== rtl/read_name_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// read_name_tokenizer_unit
// Splits read names into tokens coded against the previous name.
// ----------------------------------------------------------------------------
// Usage: send one name character per item on req_chan (char_present low
// carries no character, name_last closes the name). Each item yields zero
// or more results on rsp_chan; run_last marks the final result of an item.
// One item is worked on at a time: accept, open, character, last and finish
// steps, plus a start step for a new token and end and close steps when the
// name closes. Every token sent adds a table read, then a lookup; a string
// token adds a compare step per byte and a decision step, and an emission
// step per byte when sent literally. The per-byte steps come from the single
// read port of the previous-name string memory and the pending-byte memory,
// walked one byte per cycle; emission waits while the output is stalled. Each
// result is staged until the next result of the item is ready or the item
// finishes, so results trail by one and the last leaves at the finish step.
// A stalled receiver holds the output register; one more result waits in a
// staging register and the sequencer waits until it can move on.
// Reset clears the name state: the first name is coded with no previous
// name. Memories need no clearing; entries are only read once written.
// ----------------------------------------------------------------------------
module read_name_tokenizer_unit
   import rnt_pkg::*;
#(
   parameter int MAX_TOKENS      = 64,
   parameter int MAX_STRING_LEN  = 32,
   parameter int NUMBER_CAP_LOG2 = 26
) (
   input  logic   clock,
   input  logic   reset,
   rnt_req_if.sink   req_chan,
   rnt_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rnt_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rnt_dp #(
      .MAX_TOKENS      (MAX_TOKENS),
      .MAX_STRING_LEN  (MAX_STRING_LEN),
      .NUMBER_CAP_LOG2 (NUMBER_CAP_LOG2)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_char_code    (req_chan.char_code),
      .req_char_present (req_chan.char_present),
      .req_name_last    (req_chan.name_last),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_token_kind   (rsp_chan.token_kind),
      .rsp_token_value  (rsp_chan.token_value),
      .rsp_string_char  (rsp_chan.string_char),
      .rsp_token_done   (rsp_chan.token_done),
      .rsp_run_last     (rsp_chan.run_last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
